FILE: rtl/core/isq_pkg.sv
`default_nettype none

package isq_pkg;

  // Default build sizes
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned WORD_WIDTH_DEF = 32;

  // Fixed field widths of the request and response
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ERR_W  = 2;
  localparam int unsigned LEN_W  = 5;

  // Cell index width covers the largest store (256 entries)
  localparam int unsigned IDX_W = 8;
  // Width for range checks: counts up to 256, position plus run up to 62
  localparam int unsigned CMP_W = 10;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  // Response error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // Per-cycle action broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_UP   = 2'd2,
    CELL_DOWN = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           kind;
    logic [IDX_W-1:0]   tgt_pos;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_pos;
    logic               last_en;
    logic [IDX_W-1:0]   last_pos;
  } cell_ctl_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  run_length;
    logic [DATA_W-1:0] data_word;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_word;
    logic [ERR_W-1:0]  error_code;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] first_word;
    logic [DATA_W-1:0] last_word;
  } out_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/isq_cell.sv
`default_nettype none

module isq_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned WORD_WIDTH = isq_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  isq_pkg::cell_ctl_t    ctl,
  input  logic [WORD_WIDTH-1:0] load_word,
  input  logic [WORD_WIDTH-1:0] left_word,
  input  logic [WORD_WIDTH-1:0] right_word,
  input  logic [WORD_WIDTH-1:0] rd_chain_in,
  input  logic [WORD_WIDTH-1:0] last_chain_in,
  output logic [WORD_WIDTH-1:0] word_out,
  output logic [WORD_WIDTH-1:0] rd_chain_out,
  output logic [WORD_WIDTH-1:0] last_chain_out
);
  import isq_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [WORD_WIDTH-1:0] word_r;

  // Entry storage: load, take from lower neighbor, or take from upper neighbor
  always_ff @(posedge clk) begin
    case (ctl.kind)
      CELL_LOAD: begin
        if (ctl.tgt_pos == MY_IDX) word_r <= load_word;
      end
      CELL_UP: begin
        if (MY_IDX > ctl.tgt_pos) word_r <= left_word;
        else if (MY_IDX == ctl.tgt_pos) word_r <= load_word;
      end
      CELL_DOWN: begin
        if (MY_IDX >= ctl.tgt_pos) word_r <= right_word;
      end
      default: begin
      end
    endcase
  end

  assign word_out = word_r;

  // Read buses: the addressed cell ORs its word onto the passing chain
  assign rd_chain_out = rd_chain_in |
                        ((ctl.rd_en && ctl.rd_pos == MY_IDX) ? word_r : '0);
  assign last_chain_out = last_chain_in |
                          ((ctl.last_en && ctl.last_pos == MY_IDX) ? word_r : '0);

endmodule

`default_nettype wire

FILE: rtl/core/indexed_sequence_store.sv
`default_nettype none

// Bounded ordered store of up to CAPACITY words kept in a row of cells, one
// entry per cell. A request is taken when start is high while busy is low; its
// response appears on out_rsp for a single cycle with out_valid high and must be
// captured then, since there is no back-pressure. Each request passes through
// EXEC and REPORT before the next is taken (busy drops in the response cycle).
// A successful erase of n entries repeats EXEC for each entry, as the cell row
// moves entries down by one place per cycle. Insert shifts the whole tail up
// together. Failed requests change nothing and report an error code.

module indexed_sequence_store #(
  parameter int unsigned CAPACITY   = isq_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_WIDTH = isq_pkg::WORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  isq_pkg::in_req_t  in_req,
  output logic              busy,
  output logic              out_valid,
  output isq_pkg::out_rsp_t out_rsp
);
  import isq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r;
  in_req_t              req_r;
  logic [ERR_W-1:0]     err_r;
  logic [POS_W-1:0]     run_left_r;
  out_rsp_t             rsp_r;
  logic                 out_valid_r;

  logic [ERR_W-1:0]     acc_err;
  logic [CMP_W-1:0]     cnt_e;
  logic [CMP_W-1:0]     pos_e;
  logic [CMP_W-1:0]     run_e;
  logic [CMP_W-1:0]     cap_e;

  cell_ctl_t             ctl;
  logic [WORD_WIDTH-1:0] load_word;
  logic [WORD_WIDTH-1:0] cell_word  [CAPACITY];
  logic [WORD_WIDTH-1:0] rd_chain   [CAPACITY+1];
  logic [WORD_WIDTH-1:0] last_chain [CAPACITY+1];

  // Range and capacity checks on the incoming request
  always_comb begin
    cnt_e   = CMP_W'(count_r);
    pos_e   = CMP_W'(in_req.position);
    run_e   = CMP_W'(in_req.run_length);
    cap_e   = CMP_W'(CAPACITY);
    acc_err = ERR_OK;
    case (in_req.operation)
      OP_APPEND: begin
        if (cnt_e >= cap_e) acc_err = ERR_FULL;
      end
      OP_REMOVE: begin
        if (cnt_e == '0) acc_err = ERR_RANGE;
      end
      OP_INSERT: begin
        if (pos_e > cnt_e) acc_err = ERR_RANGE;
        else if (cnt_e >= cap_e) acc_err = ERR_FULL;
      end
      OP_ERASE: begin
        if (pos_e >= cnt_e || pos_e + run_e > cnt_e) acc_err = ERR_RANGE;
      end
      OP_READ: begin
        if (pos_e >= cnt_e) acc_err = ERR_RANGE;
      end
      OP_CLEAR: begin
      end
      default: begin
        acc_err = ERR_RANGE;
      end
    endcase
  end

  // Cell row commands: modify in EXEC, select read taps in REPORT
  always_comb begin
    ctl      = '0;
    ctl.kind = CELL_HOLD;
    case (state_r)
      ST_EXEC: begin
        if (err_r == ERR_OK) begin
          case (req_r.operation)
            OP_APPEND: begin
              ctl.kind    = CELL_LOAD;
              ctl.tgt_pos = IDX_W'(count_r);
            end
            OP_INSERT: begin
              ctl.kind    = CELL_UP;
              ctl.tgt_pos = IDX_W'(req_r.position);
            end
            OP_ERASE: begin
              if (run_left_r != '0) begin
                ctl.kind    = CELL_DOWN;
                ctl.tgt_pos = IDX_W'(req_r.position);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REPORT: begin
        ctl.rd_en    = (req_r.operation == OP_READ) && (err_r == ERR_OK);
        ctl.rd_pos   = IDX_W'(req_r.position);
        ctl.last_en  = (count_r != '0);
        ctl.last_pos = IDX_W'(count_r - CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  assign load_word     = WORD_WIDTH'(req_r.data_word);
  assign rd_chain[0]   = '0;
  assign last_chain[0] = '0;

  // Row of entry cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end

    isq_cell #(
      .IDX        (g),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk            (clk),
      .ctl            (ctl),
      .load_word      (load_word),
      .left_word      (left_w),
      .right_word     (right_w),
      .rd_chain_in    (rd_chain[g]),
      .last_chain_in  (last_chain[g]),
      .word_out       (cell_word[g]),
      .rd_chain_out   (rd_chain[g+1]),
      .last_chain_out (last_chain[g+1])
    );
  end

  // Sequencer: state, entry count and registered response
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_r      <= in_req;
            err_r      <= acc_err;
            run_left_r <= in_req.run_length;
            state_r    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r <= ST_REPORT;
          if (err_r == ERR_OK) begin
            case (req_r.operation)
              OP_APPEND, OP_INSERT: count_r <= count_r + CNT_W'(1);
              OP_REMOVE:            count_r <= count_r - CNT_W'(1);
              OP_CLEAR:             count_r <= '0;
              OP_ERASE: begin
                // one place per cycle until the run is gone
                if (run_left_r != '0) begin
                  count_r    <= count_r - CNT_W'(1);
                  run_left_r <= run_left_r - POS_W'(1);
                  if (run_left_r != POS_W'(1)) state_r <= ST_EXEC;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_REPORT: begin
          out_valid_r      <= 1'b1;
          rsp_r.read_word  <= DATA_W'(rd_chain[CAPACITY]);
          rsp_r.error_code <= err_r;
          rsp_r.length     <= LEN_W'(count_r);
          rsp_r.first_word <= (count_r != '0) ? DATA_W'(cell_word[0]) : '0;
          rsp_r.last_word  <= DATA_W'(last_chain[CAPACITY]);
          state_r          <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule

`default_nettype wire

FILE: rtl/core/isq_checker.sv
`default_nettype none

module isq_checker #(
  parameter int unsigned CAPACITY = isq_pkg::CAPACITY_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input isq_pkg::out_rsp_t out_rsp
);
  import isq_pkg::*;

  // An accepted request occupies the block on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A response strobe lasts a single cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("response strobe longer than one cycle");

  // The block is free again when its response is shown
  a_idle_on_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while response is shown");

  // Only a successful read returns a nonzero read word
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.error_code != ERR_OK) |-> (out_rsp.read_word == '0))
    else $error("read word nonzero on failed request");

  // An empty store reports zero first and last entries
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (CAPACITY < 32 && out_valid && out_rsp.length == '0) |->
      (out_rsp.first_word == '0 && out_rsp.last_word == '0))
    else $error("empty store reports nonzero end entries");

endmodule

bind indexed_sequence_store isq_checker #(
  .CAPACITY (CAPACITY)
) u_isq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

`default_nettype wire

FILE: test/isq_checker.sv
// Watches the request and response channels of the store, keeps its own
// copy of the entries and predicts every response in order.
module isq_scoreboard
  import isq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_req_t          in_req,
  input  logic             out_valid,
  input  out_rsp_t         out_rsp,
  output int               fail_count,
  output int               pending,
  output int               rsp_count,
  output logic [LEN_W-1:0] store_len
);

  localparam int unsigned DEPTH      = CAPACITY_DEF;
  localparam int          OWED_DEPTH = 4;

  // Shadow copy of the store
  logic [DATA_W-1:0] cells [DEPTH];
  int unsigned       cnt;

  // Responses owed, oldest first, in a small ring
  out_rsp_t   owed_mem [OWED_DEPTH];
  logic [1:0] owed_wr;
  logic [1:0] owed_rd;
  int         owed_cnt;
  out_rsp_t   want;

  assign store_len = LEN_W'(cnt);

  // Apply one request to the shadow store and build its response
  function automatic out_rsp_t apply_request(in_req_t r);
    out_rsp_t    rsp;
    int unsigned pos;
    int unsigned run;
    rsp = '0;
    pos = r.position;
    run = r.run_length;
    case (r.operation)
      OP_APPEND: begin
        if (cnt >= DEPTH) begin
          rsp.error_code = ERR_FULL;
        end else begin
          cells[cnt] = r.data_word;
          cnt++;
        end
      end
      OP_REMOVE: begin
        if (cnt == 0) rsp.error_code = ERR_RANGE;
        else cnt--;
      end
      OP_INSERT: begin
        // position is checked before fullness
        if (pos > cnt) begin
          rsp.error_code = ERR_RANGE;
        end else if (cnt >= DEPTH) begin
          rsp.error_code = ERR_FULL;
        end else begin
          for (int unsigned i = cnt; i > pos; i--) cells[i] = cells[i-1];
          cells[pos] = r.data_word;
          cnt++;
        end
      end
      OP_ERASE: begin
        // a run ending exactly at the tail is legal
        if (pos >= cnt || pos + run > cnt) begin
          rsp.error_code = ERR_RANGE;
        end else if (run != 0) begin
          for (int unsigned i = pos; i + run < cnt; i++) cells[i] = cells[i+run];
          cnt -= run;
        end
      end
      OP_READ: begin
        if (pos >= cnt) rsp.error_code = ERR_RANGE;
        else rsp.read_word = cells[pos];
      end
      OP_CLEAR: cnt = 0;
      default: rsp.error_code = ERR_RANGE;
    endcase
    rsp.length = LEN_W'(cnt);
    if (cnt != 0) begin
      rsp.first_word = cells[0];
      rsp.last_word  = cells[cnt-1];
    end
    return rsp;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare responses first, then record the request taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cnt      = 0;
      owed_wr  = '0;
      owed_rd  = '0;
      owed_cnt = 0;
    end else begin
      if (out_valid) begin
        rsp_count++;
        if (owed_cnt == 0) begin
          $display("%0t: response with no request waiting, actual %h", $time, out_rsp);
          fail_count++;
        end else begin
          want     = owed_mem[owed_rd];
          owed_rd  = owed_rd + 2'd1;
          owed_cnt--;
          check_field("read_word",  want.read_word,  out_rsp.read_word);
          check_field("error_code", want.error_code, out_rsp.error_code);
          check_field("length",     want.length,     out_rsp.length);
          check_field("first_word", want.first_word, out_rsp.first_word);
          check_field("last_word",  want.last_word,  out_rsp.last_word);
        end
      end
      if (start && !busy) begin
        if (owed_cnt == OWED_DEPTH) begin
          $display("%0t: too many requests in flight, expected at most %0d, actual %0d",
                   $time, OWED_DEPTH, owed_cnt + 1);
          fail_count++;
        end else begin
          owed_mem[owed_wr] = apply_request(in_req);
          owed_wr           = owed_wr + 2'd1;
          owed_cnt++;
        end
      end
    end
    pending = owed_cnt;
  end

endmodule

FILE: test/indexed_sequence_store_tb.sv
module indexed_sequence_store_tb;
  import isq_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int RAND_ITEMS = 950;
  localparam int LIMIT      = 200000;

  // Operation codes with no defined meaning
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic       clk    = 1'b0;
  logic       rst_n  = 1'b0;
  logic       start  = 1'b0;
  in_req_t    in_req = '0;
  logic       busy;
  logic       out_valid;
  out_rsp_t   out_rsp;

  int               fail_count;
  int               pending;
  int               rsp_count;
  logic [LEN_W-1:0] store_len;
  int               sent;
  int               cycles;

  always #5 clk = ~clk;

  indexed_sequence_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  isq_scoreboard chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .rsp_count  (rsp_count),
    .store_len  (store_len)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Entered and left at a falling edge; holds the request until taken
  task automatic send(input logic [OP_W-1:0] op, input int pos, input int run,
                      input logic [DATA_W-1:0] word);
    start  <= 1'b1;
    in_req <= '{operation: op, position: POS_W'(pos), run_length: POS_W'(run),
                data_word: word};
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  // n must be at least one
  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed requests against the current length, some noise
  task automatic random_request();
    int len;
    int sel;
    int op;
    int pos;
    int run;
    len = store_len;
    sel = $urandom_range(0, 99);
    if (sel < 25)      op = OP_APPEND;
    else if (sel < 45) op = OP_INSERT;
    else if (sel < 60) op = OP_ERASE;
    else if (sel < 80) op = OP_READ;
    else if (sel < 90) op = OP_REMOVE;
    else if (sel < 94) op = OP_CLEAR;
    else               op = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
    if ($urandom_range(0, 99) < 85) begin
      if (op == OP_INSERT) pos = $urandom_range(0, len);
      else if (len > 0)    pos = $urandom_range(0, len - 1);
      else                 pos = 0;
    end else begin
      pos = $urandom_range(0, 31);
    end
    sel = $urandom_range(0, 99);
    if (len > pos && sel < 50)      run = $urandom_range(0, (len - pos > 3) ? 3 : len - pos);
    else if (len > pos && sel < 80) run = $urandom_range(0, len - pos);
    else                            run = $urandom_range(0, 31);
    send(OP_W'(op), pos, run, rand_word());
  endtask

  initial begin
    int burst;
    int n;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Empty store corners and unused codes
    send(OP_READ,      0, 0, '0);
    send(OP_REMOVE,    0, 0, '0);
    send(OP_ERASE,     0, 0, '0);
    send(OP_SPARE_LO,  0, 0, '1);
    send(OP_SPARE_HI, 31, 31, '1);
    // Build up: append, insert at front, insert at the tail, insert past it
    send(OP_APPEND,  0,  0, '0);
    send(OP_APPEND, 31, 31, '1);
    send(OP_INSERT,  0,  0, 32'hA5A5_5A5A);
    send(OP_INSERT,  3,  0, 32'h1234_5678);
    send(OP_INSERT,  5,  0, 32'hDEAD_BEEF);
    send(OP_READ,    1,  0, '0);
    send(OP_READ,    4,  0, '0);
    // Erase: zero run, run to the tail, start at length, run past the tail
    send(OP_ERASE,   1,  0, '0);
    send(OP_ERASE,   2,  2, '0);
    send(OP_ERASE,   2,  0, '0);
    send(OP_ERASE,   1,  2, '0);
    // Full store
    while (store_len < CAP) send(OP_APPEND, 0, 0, rand_word());
    send(OP_APPEND,  0,  0, 32'h0F0F_0F0F);
    send(OP_INSERT,  5,  0, 32'hF0F0_F0F0);
    send(OP_INSERT, 31,  0, 32'hF0F0_F0F0);
    send(OP_READ,   15,  0, '0);
    send(OP_ERASE,   0, 16, '0);
    send(OP_APPEND,  0,  0, 32'h8000_0001);
    send(OP_CLEAR,  31, 31, '1);

    // Random bursts with random gaps
    n = 0;
    while (n < RAND_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      repeat (burst) begin
        random_request();
        n++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
    end

    // Drain
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("Covered %0d requests and %0d responses over all operations and unused codes,",
             sent, rsp_count);
    $display("including empty and full store corners, erase to the tail and bursty issue.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: indexed_sequence_store.f
rtl/core/isq_pkg.sv
rtl/core/isq_cell.sv
rtl/core/indexed_sequence_store.sv
rtl/core/isq_checker.sv
test/isq_checker.sv
test/indexed_sequence_store_tb.sv
